FILE: rtl/canonical_huffman_bit_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef CANONICAL_HUFFMAN_BIT_DECODER_MACROS_SVH
`define CANONICAL_HUFFMAN_BIT_DECODER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CHBD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chbd assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define CHBD_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chbd assertion failed");

`endif

FILE: rtl/chbd_pkg.sv
// Types and constants for the canonical Huffman bit decoder.
`timescale 1ns / 1ps
`default_nettype none

package chbd_pkg;

    localparam int MAX_CODE_LENGTH = 16;
    localparam int SYMBOL_DEPTH    = 256;
    localparam int NUM_LENGTHS     = 16;

    localparam int LEN_AW  = $clog2(NUM_LENGTHS);
    localparam int LEN_W   = LEN_AW + 1;
    localparam int SYM_AW  = $clog2(SYMBOL_DEPTH);
    localparam int IDX_W   = 9;
    localparam int COUNT_W = 8;
    localparam int MINC_W  = 16;
    localparam int MAXC_W  = 17;
    localparam int BASE_W  = 9;
    localparam int TOTAL_W = BASE_W + 1;
    localparam int CODE_W  = NUM_LENGTHS + 2;
    localparam int POS_W   = MINC_W + 1;

    localparam logic [MAXC_W-1:0] NO_CODE = '1;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_DECODE = 2'd2;

    localparam logic [1:0] ST_MORE      = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_INVALID   = 2'd2;
    localparam logic [1:0] ST_TABLE_ERR = 2'd3;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [IDX_W-1:0] table_index;
        logic [7:0]       table_byte;
        logic             code_bit;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] symbol;
    } out_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [MINC_W-1:0]  min_code;
        logic [MAXC_W-1:0]  max_code;
        logic [BASE_W-1:0]  sym_base;
    } len_entry_t;

    typedef struct packed {
        logic              en;
        logic [LEN_AW-1:0] addr;
        len_entry_t        data;
    } tbl_wr_t;

    typedef struct packed {
        logic              en;
        logic [SYM_AW-1:0] addr;
        logic [7:0]        data;
    } sym_wr_t;

endpackage

`default_nettype wire

FILE: rtl/chbd_tables.sv
// Per-length table memory with entry valid bits, and the symbol memory.
`timescale 1ns / 1ps
`default_nettype none

module chbd_tables (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire chbd_pkg::tbl_wr_t           tbl_wr,
    input  wire logic [chbd_pkg::LEN_AW-1:0] tbl_raddr,
    output chbd_pkg::len_entry_t             tbl_rdata,
    input  wire chbd_pkg::sym_wr_t           sym_wr,
    input  wire logic [chbd_pkg::SYM_AW-1:0] sym_raddr,
    output logic [7:0]                       sym_rdata
);
    import chbd_pkg::*;

    len_entry_t             tbl_mem [NUM_LENGTHS];
    logic [7:0]             sym_mem [SYMBOL_DEPTH];
    logic [NUM_LENGTHS-1:0] ent_valid_reg;
    len_entry_t             tbl_rd_reg;
    logic                   tbl_rd_valid_reg;
    logic [7:0]             sym_rd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg    <= '0;
            tbl_rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (tbl_wr.en)
            begin
                ent_valid_reg[tbl_wr.addr] <= 1'b1;
            end
            tbl_rd_valid_reg <= ent_valid_reg[tbl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tbl_wr.en)
        begin
            tbl_mem[tbl_wr.addr] <= tbl_wr.data;
        end
        tbl_rd_reg <= tbl_mem[tbl_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (sym_wr.en)
        begin
            sym_mem[sym_wr.addr] <= sym_wr.data;
        end
        sym_rd_reg <= sym_mem[sym_raddr];
    end

    // never-written entries read as the reset value
    assign tbl_rdata = tbl_rd_valid_reg ? tbl_rd_reg : '0;
    assign sym_rdata = sym_rd_reg;

endmodule

`default_nettype wire

FILE: rtl/canonical_huffman_bit_decoder.sv
// Top level of the canonical Huffman bit decoder.
`timescale 1ns / 1ps
`default_nettype none
`include "canonical_huffman_bit_decoder_macros.svh"

// Loads a JPEG-style table (16 length counts, then symbols in code order),
// builds it on a finish item and then decodes one code bit per item. Each
// decode item gives one result: more bits needed, symbol found, invalid code
// after 16 bits, or table error. Steps per item: a table write or no-op is
// taken while idle; a decode bit reads the per-length memory, then compares,
// then reads the symbol memory if the matched code is in the store; a finish
// item walks the per-length memory one length at a time from the first read
// and ends early at the first length that breaks the table. A result that
// cannot enter the output register holds the block in its current step.
module canonical_huffman_bit_decoder (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire chbd_pkg::in_item_t  req,
    output logic                     rsp_valid,
    input  wire logic                rsp_ready,
    output chbd_pkg::out_item_t      rsp
);
    import chbd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BUILD,
        S_LOOK,
        S_SYM,
        S_NOTAB
    } state_t;

    state_t              state_reg,  state_next;
    logic [MINC_W-1:0]   rc_reg,     rc_next;
    logic [LEN_W-1:0]    rl_reg,     rl_next;
    logic [LEN_AW-1:0]   idx_reg,    idx_next;
    logic [CODE_W-1:0]   code_reg,   code_next;
    logic [TOTAL_W-1:0]  total_reg,  total_next;
    logic [SYM_AW-1:0]   pos_reg,    pos_next;
    logic                table_valid_reg, table_valid_next;
    logic                out_valid_reg,   out_valid_next;
    out_item_t           out_item_reg,    out_item_next;

    tbl_wr_t             tbl_wr;
    logic [LEN_AW-1:0]   tbl_raddr;
    len_entry_t          tbl_rdata;
    sym_wr_t             sym_wr;
    logic [SYM_AW-1:0]   sym_raddr;
    logic [7:0]          sym_rdata;

    logic                out_free;
    logic                emit;
    out_item_t           emit_item;

    logic [COUNT_W-1:0]  cnt;
    logic [LEN_W-1:0]    blen;
    logic [CODE_W-1:0]   code_sum;
    logic [CODE_W-1:0]   limit;
    logic [TOTAL_W-1:0]  total_sum;
    logic                bfail;

    logic                match;
    logic [MINC_W-1:0]   diff;
    logic [POS_W-1:0]    pos;
    logic                in_store;
    logic [IDX_W-1:0]    sym_off;

    chbd_tables u_tables (
        .clk       (clk),
        .rst_n     (rst_n),
        .tbl_wr    (tbl_wr),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata),
        .sym_wr    (sym_wr),
        .sym_raddr (sym_raddr),
        .sym_rdata (sym_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_item_reg;
    assign out_free  = !out_valid_reg || rsp_ready;

    // build step datapath
    assign cnt       = tbl_rdata.count;
    assign blen      = {1'b0, idx_reg} + LEN_W'(1);
    assign code_sum  = code_reg + CODE_W'(cnt);
    assign limit     = CODE_W'(1) << blen;
    assign total_sum = total_reg + TOTAL_W'(cnt);
    assign bfail     = (cnt != '0) && ((blen > LEN_W'(MAX_CODE_LENGTH)) ||
                       (code_sum > limit) || (total_sum > TOTAL_W'(SYMBOL_DEPTH)));

    // decode compare datapath
    assign match    = (tbl_rdata.max_code != NO_CODE) &&
                      ({1'b0, rc_reg} <= tbl_rdata.max_code) &&
                      (rc_reg >= tbl_rdata.min_code);
    assign diff     = rc_reg - tbl_rdata.min_code;
    assign pos      = POS_W'(tbl_rdata.sym_base) + POS_W'(diff);
    assign in_store = pos < POS_W'(SYMBOL_DEPTH);
    assign sym_off  = req.table_index - IDX_W'(NUM_LENGTHS);

    always_comb
    begin
        state_next       = state_reg;
        rc_next          = rc_reg;
        rl_next          = rl_reg;
        idx_next         = idx_reg;
        code_next        = code_reg;
        total_next       = total_reg;
        pos_next         = pos_reg;
        table_valid_next = table_valid_reg;
        out_valid_next   = out_valid_reg && !rsp_ready;
        out_item_next    = out_item_reg;
        tbl_wr           = '0;
        sym_wr           = '0;
        tbl_raddr        = LEN_AW'(rl_reg - LEN_W'(1));
        sym_raddr        = pos_reg;
        emit             = 1'b0;
        emit_item        = '0;

        case (state_reg)
            S_IDLE:
            begin
                tbl_raddr = rl_reg[LEN_AW-1:0];
                if (req_valid)
                begin
                    case (req.opcode)
                        OP_WRITE:
                        begin
                            if (req.table_index < IDX_W'(NUM_LENGTHS))
                            begin
                                tbl_wr.en         = 1'b1;
                                tbl_wr.addr       = req.table_index[LEN_AW-1:0];
                                tbl_wr.data.count = req.table_byte;
                            end
                            else if (sym_off < IDX_W'(SYMBOL_DEPTH))
                            begin
                                sym_wr.en   = 1'b1;
                                sym_wr.addr = sym_off[SYM_AW-1:0];
                                sym_wr.data = req.table_byte;
                            end
                            table_valid_next = 1'b0;
                            rc_next          = '0;
                            rl_next          = '0;
                        end
                        OP_FINISH:
                        begin
                            tbl_raddr        = '0;
                            idx_next         = '0;
                            code_next        = '0;
                            total_next       = '0;
                            table_valid_next = 1'b0;
                            rc_next          = '0;
                            rl_next          = '0;
                            state_next       = S_BUILD;
                        end
                        OP_DECODE:
                        begin
                            if (!table_valid_reg)
                            begin
                                rc_next    = '0;
                                rl_next    = '0;
                                state_next = S_NOTAB;
                            end
                            else
                            begin
                                rc_next    = {rc_reg[MINC_W-2:0], req.code_bit};
                                rl_next    = rl_reg + LEN_W'(1);
                                state_next = S_LOOK;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_BUILD:
            begin
                tbl_raddr = idx_reg;
                if (bfail)
                begin
                    if (out_free)
                    begin
                        emit             = 1'b1;
                        emit_item.status = ST_TABLE_ERR;
                        state_next       = S_IDLE;
                    end
                end
                else
                begin
                    tbl_wr.en            = 1'b1;
                    tbl_wr.addr          = idx_reg;
                    tbl_wr.data.count    = cnt;
                    tbl_wr.data.min_code = code_reg[MINC_W-1:0];
                    tbl_wr.data.sym_base = total_reg[BASE_W-1:0];
                    if (cnt != '0)
                    begin
                        tbl_wr.data.max_code = MAXC_W'(code_sum - CODE_W'(1));
                        code_next            = code_sum << 1;
                        total_next           = total_sum;
                    end
                    else
                    begin
                        tbl_wr.data.max_code = NO_CODE;
                        code_next            = code_reg << 1;
                    end
                    if (idx_reg == LEN_AW'(NUM_LENGTHS - 1))
                    begin
                        table_valid_next = 1'b1;
                        state_next       = S_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + LEN_AW'(1);
                        tbl_raddr = idx_reg + LEN_AW'(1);
                    end
                end
            end
            S_LOOK:
            begin
                if (match && in_store)
                begin
                    sym_raddr  = pos[SYM_AW-1:0];
                    pos_next   = pos[SYM_AW-1:0];
                    rc_next    = '0;
                    rl_next    = '0;
                    state_next = S_SYM;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                    if (match)
                    begin
                        emit_item.status = ST_FOUND;
                        rc_next          = '0;
                        rl_next          = '0;
                    end
                    else if (rl_reg >= LEN_W'(MAX_CODE_LENGTH))
                    begin
                        emit_item.status = ST_INVALID;
                        rc_next          = '0;
                        rl_next          = '0;
                    end
                    else
                    begin
                        emit_item.status = ST_MORE;
                    end
                end
            end
            S_SYM:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    emit_item.status = ST_FOUND;
                    emit_item.symbol = sym_rdata;
                    state_next       = S_IDLE;
                end
            end
            S_NOTAB:
            begin
                if (out_free)
                begin
                    emit             = 1'b1;
                    emit_item.status = ST_TABLE_ERR;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
            out_item_next  = emit_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            rc_reg          <= '0;
            rl_reg          <= '0;
            idx_reg         <= '0;
            code_reg        <= '0;
            total_reg       <= '0;
            pos_reg         <= '0;
            table_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            out_item_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            rc_reg          <= rc_next;
            rl_reg          <= rl_next;
            idx_reg         <= idx_next;
            code_reg        <= code_next;
            total_reg       <= total_next;
            pos_reg         <= pos_next;
            table_valid_reg <= table_valid_next;
            out_valid_reg   <= out_valid_next;
            out_item_reg    <= out_item_next;
        end
    end

    `CHBD_ASSERT_IMP(a_idle_len, state_reg == S_IDLE, rl_reg < LEN_W'(NUM_LENGTHS))
    `CHBD_ASSERT_IMP(a_sym_zero, rsp_valid && rsp.status != ST_FOUND, rsp.symbol == '0)
    `CHBD_ASSERT_IMP(a_valid_from_build, $rose(table_valid_reg), $past(state_reg == S_BUILD))
    `CHBD_ASSERT_NXT(a_restart,
        state_reg == S_LOOK && emit && emit_item.status != ST_MORE, rl_reg == '0)
    `CHBD_ASSERT_IMP(a_build_err, state_reg == S_BUILD && emit, emit_item.status == ST_TABLE_ERR)

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the canonical Huffman bit decoder.
`timescale 1ns / 1ps

import chbd_pkg::*;

class huffman_decode_tracker;
    logic [7:0]  length_count [NUM_LENGTHS];
    logic [7:0]  symbol_byte [SYMBOL_DEPTH];
    bit          symbol_known [SYMBOL_DEPTH];
    logic [15:0] min_code [NUM_LENGTHS];
    logic [16:0] max_code [NUM_LENGTHS];
    logic [8:0]  sym_base [NUM_LENGTHS];
    logic [15:0] code_acc;
    logic [4:0]  code_len;
    bit          table_built;
    out_item_t   results_due [$];
    int          mismatch_count;

    function new();
        foreach (length_count[i])
        begin
            length_count[i] = '0;
            min_code[i] = '0;
            max_code[i] = '0;
            sym_base[i] = '0;
        end
        foreach (symbol_byte[i])
        begin
            symbol_byte[i] = '0;
            symbol_known[i] = 1'b0;
        end
        code_acc = '0;
        code_len = '0;
        table_built = 1'b0;
        mismatch_count = 0;
    endfunction

    function int symbols_needed();
        int total;
        total = 0;
        foreach (length_count[i])
            total += length_count[i];
        return total;
    endfunction

    function void restart_code();
        code_acc = '0;
        code_len = '0;
    endfunction

    function bit build_code_tables();
        int unsigned code;
        int unsigned total;
        int unsigned cnt;
        code = 0;
        total = 0;
        for (int len = 1; len <= NUM_LENGTHS; len++)
        begin
            cnt = length_count[len-1];
            if (cnt != 0 && len > MAX_CODE_LENGTH)
                return 1'b0;
            min_code[len-1] = code[15:0];
            sym_base[len-1] = total[8:0];
            if (cnt != 0)
            begin
                code += cnt;
                total += cnt;
                if (code > (32'd1 << len) || total > SYMBOL_DEPTH)
                    return 1'b0;
                max_code[len-1] = 17'(code - 1);
            end
            else
                max_code[len-1] = NO_CODE;
            code = code << 1;
        end
        return 1'b1;
    endfunction

    function void note_item(in_item_t it);
        out_item_t res;
        int k;
        int pos;
        res = '0;
        case (it.opcode)
            OP_WRITE:
            begin
                if (it.table_index < NUM_LENGTHS)
                    length_count[it.table_index[3:0]] = it.table_byte;
                else if (it.table_index < NUM_LENGTHS + SYMBOL_DEPTH)
                begin
                    symbol_byte[it.table_index - NUM_LENGTHS] = it.table_byte;
                    symbol_known[it.table_index - NUM_LENGTHS] = 1'b1;
                end
                table_built = 1'b0;
                restart_code();
            end
            OP_FINISH:
            begin
                table_built = build_code_tables();
                restart_code();
                if (!table_built)
                begin
                    res.status = ST_TABLE_ERR;
                    results_due.push_back(res);
                end
            end
            OP_DECODE:
            begin
                if (!table_built)
                begin
                    restart_code();
                    res.status = ST_TABLE_ERR;
                end
                else
                begin
                    code_acc = {code_acc[14:0], it.code_bit};
                    code_len = code_len + 5'd1;
                    k = int'(code_len) - 1;
                    if (max_code[k] != NO_CODE && {1'b0, code_acc} <= max_code[k]
                        && code_acc >= min_code[k])
                    begin
                        pos = int'(sym_base[k]) + int'(code_acc) - int'(min_code[k]);
                        res.status = ST_FOUND;
                        res.symbol = (pos < SYMBOL_DEPTH) ? symbol_byte[pos] : 8'd0;
                        restart_code();
                    end
                    else if (code_len >= MAX_CODE_LENGTH)
                    begin
                        res.status = ST_INVALID;
                        restart_code();
                    end
                    else
                        res.status = ST_MORE;
                end
                results_due.push_back(res);
            end
            default:
                ;
        endcase
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        if (results_due.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: status %0d symbol %h", got.status, got.symbol);
            return;
        end
        want = results_due.pop_front();
        if (got.status !== want.status || got.symbol !== want.symbol)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("mismatch: status exp %0d got %0d, symbol exp %h got %h",
                         want.status, got.status, want.symbol, got.symbol);
        end
    endfunction
endclass

module tb;
    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 750;
    localparam int SETTLE_CYCLES = 60;
    localparam int TYPICAL_TABLE_SYMBOLS = 16;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    in_item_t  req = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    out_item_t rsp;

    huffman_decode_tracker tracker;
    logic [7:0] plan_counts [NUM_LENGTHS];
    int items_sent = 0;
    int cycle_count = 0;
    bit calm = 1'b0;

    canonical_huffman_bit_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
        rsp_ready <= calm || ($urandom_range(0, 99) >= 13);

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            tracker.check_result(rsp);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic drive_item(input logic [1:0] op, input logic [8:0] idx,
                              input logic [7:0] val, input logic b);
        in_item_t it;
        it.opcode = op;
        it.table_index = idx;
        it.table_byte = val;
        it.code_bit = b;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 13)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req_valid <= 1'b1;
        req <= it;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        tracker.note_item(it);
        if (op != OP_NOP && !(op == OP_WRITE && idx >= NUM_LENGTHS + SYMBOL_DEPTH))
            items_sent++;
    endtask

    task automatic write_byte(input int idx, input logic [7:0] val);
        drive_item(OP_WRITE, idx[8:0], val, 1'($urandom_range(0, 1)));
    endtask

    task automatic decode_bit(input logic b);
        drive_item(OP_DECODE, 9'($urandom_range(0, 511)), 8'($urandom), b);
    endtask

    // symbols the next build can reach are written before it
    task automatic finish_table();
        int need;
        need = tracker.symbols_needed();
        if (need <= SYMBOL_DEPTH)
        begin
            for (int p = 0; p < need; p++)
            begin
                if (!tracker.symbol_known[p])
                    write_byte(NUM_LENGTHS + p, 8'($urandom));
            end
        end
        drive_item(OP_FINISH, 9'($urandom_range(0, 511)), 8'($urandom),
                   1'($urandom_range(0, 1)));
    endtask

    task automatic apply_plan(input bit write_all);
        for (int l = 0; l < NUM_LENGTHS; l++)
        begin
            if (write_all || tracker.length_count[l] != plan_counts[l])
                write_byte(l, plan_counts[l]);
        end
    endtask

    task automatic load_plan_table(input bit write_all);
        int total;
        apply_plan(write_all);
        total = tracker.symbols_needed();
        if (total > 2 * TYPICAL_TABLE_SYMBOLS)
            total = TYPICAL_TABLE_SYMBOLS;
        for (int p = 0; p < total; p++)
            write_byte(NUM_LENGTHS + p, 8'($urandom));
        finish_table();
    endtask

    task automatic make_plan(input int max_len, input int sym_cap, input bit fill);
        int unsigned code;
        int total;
        int limit;
        code = 0;
        total = 0;
        for (int l = 1; l <= NUM_LENGTHS; l++)
        begin
            plan_counts[l-1] = 8'd0;
            if (l <= max_len)
            begin
                limit = (1 << l) - int'(code);
                if (limit > 255)
                    limit = 255;
                if (limit > sym_cap - total)
                    limit = sym_cap - total;
                if (fill && l == max_len)
                    plan_counts[l-1] = 8'(limit);
                else
                    plan_counts[l-1] = 8'($urandom_range(0, (limit + 1) / 2));
                total += plan_counts[l-1];
            end
            code = (code + plan_counts[l-1]) << 1;
        end
    endtask

    task automatic decode_position(input int p);
        int k;
        int l;
        logic [15:0] code;
        k = 0;
        for (l = 0; l < NUM_LENGTHS; l++)
        begin
            if (tracker.length_count[l] != 0 && p >= tracker.sym_base[l]
                && p < tracker.sym_base[l] + tracker.length_count[l])
                k = l;
        end
        code = tracker.min_code[k] + 16'(p - tracker.sym_base[k]);
        for (l = k; l >= 0; l--)
            decode_bit(code[l]);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        @(posedge clk);
        while (tracker.results_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int segment;
        int pick;
        int r;
        int max_len;
        int total;
        int k;
        int random_end;
        logic [1:0] op;

        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        decode_bit(1'b0);
        drive_item(OP_NOP, 9'h1FF, 8'hFF, 1'b1);
        write_byte(300, 8'hAA);
        // empty table: every code runs out at full length
        finish_table();
        repeat (MAX_CODE_LENGTH) decode_bit(1'($urandom_range(0, 1)));
        foreach (plan_counts[l]) plan_counts[l] = 8'd0;
        plan_counts[0] = 8'd3;
        apply_plan(1'b0);
        finish_table();
        decode_bit(1'b1);
        // length 1 full: all-ones code must decode
        plan_counts[0] = 8'd2;
        apply_plan(1'b0);
        write_byte(NUM_LENGTHS, 8'h00);
        write_byte(NUM_LENGTHS + 1, 8'hFF);
        finish_table();
        decode_bit(1'b1);
        decode_bit(1'b0);
        // 257 symbols
        plan_counts[0] = 8'd0;
        plan_counts[8] = 8'd255;
        plan_counts[9] = 8'd2;
        apply_plan(1'b0);
        finish_table();
        write_byte(NUM_LENGTHS + SYMBOL_DEPTH - 1, 8'h5A);

        random_end = items_sent + RANDOM_ITEMS;
        segment = 0;
        while (items_sent < random_end)
        begin
            calm = (segment >= 6 && segment < 10);
            pick = $urandom_range(0, 99);
            if (segment == 2 || pick < 1)
            begin
                foreach (plan_counts[l]) plan_counts[l] = 8'd0;
                plan_counts[7] = 8'($urandom_range(200, 255));
                plan_counts[8] = 8'(SYMBOL_DEPTH - plan_counts[7]);
                load_plan_table(1'b0);
                repeat ($urandom_range(8, 20))
                    decode_position($urandom_range(0, SYMBOL_DEPTH - 1));
            end
            else if (pick < 75)
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    max_len = $urandom_range(1, 5);
                else if (r < 90)
                    max_len = $urandom_range(6, 11);
                else
                    max_len = $urandom_range(12, 16);
                make_plan(max_len, TYPICAL_TABLE_SYMBOLS, 1'($urandom_range(0, 1)));
                load_plan_table($urandom_range(0, 7) == 0);
                total = tracker.symbols_needed();
                repeat ($urandom_range(4, 24))
                begin
                    if (total > 0 && $urandom_range(0, 9) != 0)
                        decode_position($urandom_range(0, total - 1));
                    else
                        repeat ($urandom_range(1, 6)) decode_bit(1'($urandom_range(0, 1)));
                end
            end
            else if (pick < 87)
            begin
                foreach (plan_counts[l]) plan_counts[l] = 8'd0;
                k = $urandom_range(0, 5);
                plan_counts[k] = 8'((1 << (k + 1)) + $urandom_range(1, 3));
                apply_plan(1'b0);
                finish_table();
                repeat ($urandom_range(1, 3)) decode_bit(1'($urandom_range(0, 1)));
            end
            else
            begin
                repeat ($urandom_range(3, 12))
                begin
                    op = 2'($urandom_range(0, 3));
                    if (op == OP_FINISH)
                        finish_table();
                    else
                        drive_item(op, 9'($urandom_range(0, 511)), 8'($urandom),
                                   1'($urandom_range(0, 1)));
                end
            end
            if (segment == 1 || $urandom_range(0, 4) == 0)
                wait_for_results();
            segment++;
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.mismatch_count == 0 && tracker.results_due.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
